// ===== design/pressure_sensor_compensation_macros.svh =====
// Assertion macros for the pressure sensor compensation block.
// Included by design files that carry concurrent checks; no dependencies.
`ifndef PRESSURE_SENSOR_COMPENSATION_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_MACROS_SVH

`ifndef SYNTHESIS

`define PSC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define PSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PSC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define PSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/psc_pkg.sv =====
// Shared types and constants for the pressure sensor compensation block.
// No dependencies; used by pressure_sensor_compensation.
`timescale 1ns / 1ps

package psc_pkg;

	localparam int CFG_W      = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int PIPE_DEPTH = 12;

	localparam logic [CFG_IDX_W-1:0] REG_C1      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C2      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C3      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_C4      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C5      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C6      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SURFACE = 3'd6;

	localparam logic [18:0] SURFACE_RESET = 19'd9850;

	localparam int TEMP_BASE   = 2000;
	localparam int TEMP_MIN    = -4000;
	localparam int TEMP_MAX    = 8500;
	localparam int PRES_MAX    = 300000;
	localparam int DEPTH_LIMIT = 300000;

	localparam logic signed [17:0] DEPTH_SCALE = 18'sd64679;

	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} sample_t;

	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic        [18:0] pressure_tenth_mbar;
		logic signed [19:0] depth_value;
	} result_t;

endpackage

// ===== design/pressure_sensor_compensation.sv =====
// Pressure sensor compensation: twelve-stage pipeline, coefficient registers.
// Depends on psc_pkg and pressure_sensor_compensation_macros.svh.
`timescale 1ns / 1ps
`include "pressure_sensor_compensation_macros.svh"

// Usage
//   Configuration: write cfg_data to register cfg_index with cfg_we high for one
//   cycle (0..5: coefficients C1..C6, 6: surface reference). Write only while idle.
//   Index 7 is ignored.
//   Input: an item (raw pressure and raw temperature) is taken at each rising
//   edge where start is high and busy is low. busy stays low: one item per cycle.
//   Output: done pulses for one cycle with the item's result on result;
//   results come out in input order.
//   Throughput: one item per cycle, set by the twelve-stage datapath with one
//   multiplier level per stage (the 24 x 38 bit pressure product is split into
//   two partial products and summed in the next stage).
//   The receiver cannot stall; every result is shown exactly once.
//   Reset (arst_n low) empties the pipeline, clears C1..C6 and sets the
//   surface reference to 9850.

module pressure_sensor_compensation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  psc_pkg::sample_t                    sample,
	output logic                                done,
	output psc_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psc_pkg::CFG_W-1:0]           cfg_data
);
	import psc_pkg::*;

	logic [15:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic [18:0] surf_q;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic accept;

	// stage registers
	logic [23:0] d1_s1, d1_s2, d1_s3, d1_s4, d1_s5;
	logic signed [24:0] dt_s1;
	logic signed [41:0] mt_s2, mo_s2, ms_s2;
	logic [48:0] dd_s2;
	logic signed [18:0] dtemp_s3;
	logic signed [35:0] off_s3, off_s4;
	logic signed [34:0] sens_s3, sens_s4;
	logic [17:0] tilo_s3;
	logic [12:0] tihi_s3;
	logic [36:0] aux_s4;
	logic neg_s4;
	logic signed [14:0] t_s4, t_s5, t_s6, t_s7, t_s8, t_s9, t_s10, t_s11;
	logic signed [39:0] off_s5, off_s6, off_s7, off_s8;
	logic signed [37:0] sens_s5;
	logic [42:0] pplo_s6;
	logic signed [43:0] pphi_s6;
	logic signed [62:0] prod_s7;
	logic signed [41:0] q_s8;
	logic signed [42:0] diff_s9;
	logic [18:0] p_s10, p_s11;
	logic signed [37:0] dprod_s11;
	result_t result_s12;

	// combinational
	logic signed [24:0] dt_c;
	logic signed [49:0] dd_full;
	logic signed [41:0] mt_b, mo_b, ms_b;
	logic signed [34:0] mo_tr;
	logic signed [33:0] ms_tr;
	logic [50:0] dd3;
	logic signed [37:0] aux_full;
	logic [17:0] ti_sel;
	logic signed [20:0] tsum;
	logic signed [14:0] t_c;
	logic [38:0] aux3;
	logic [39:0] aux5;
	logic [37:0] offi;
	logic [36:0] sensi;
	logic signed [62:0] prod_b;
	logic signed [42:0] diff_b;
	logic signed [29:0] praw;
	logic [18:0] p_c;
	logic signed [19:0] dsub;
	logic signed [21:0] dsh;
	logic signed [19:0] depth_c;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign done   = vld_q[PIPE_DEPTH-1];
	assign result = result_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q   <= '0;
			c2_q   <= '0;
			c3_q   <= '0;
			c4_q   <= '0;
			c5_q   <= '0;
			c6_q   <= '0;
			surf_q <= SURFACE_RESET;
			vld_q  <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
			if (cfg_we) begin
				case (cfg_index)
					REG_C1:      c1_q   <= cfg_data[15:0];
					REG_C2:      c2_q   <= cfg_data[15:0];
					REG_C3:      c3_q   <= cfg_data[15:0];
					REG_C4:      c4_q   <= cfg_data[15:0];
					REG_C5:      c5_q   <= cfg_data[15:0];
					REG_C6:      c6_q   <= cfg_data[15:0];
					REG_SURFACE: surf_q <= cfg_data[18:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		// s1: dT
		dt_c = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, c5_q, 8'd0});

		// s2: dT squared
		dd_full = dt_s1 * dt_s1;

		// s3: truncating shifts, OFF, SENS, Ti candidates
		mt_b  = mt_s2 + $signed({19'd0, {23{mt_s2[41]}}});
		mo_b  = mo_s2 + $signed({35'd0, {7{mo_s2[41]}}});
		ms_b  = ms_s2 + $signed({34'd0, {8{ms_s2[41]}}});
		mo_tr = $signed(mo_b[41:7]);
		ms_tr = $signed(ms_b[41:8]);
		dd3   = {2'b00, dd_s2} + {1'b0, dd_s2, 1'b0};

		// s4: temperature
		aux_full = dtemp_s3 * dtemp_s3;
		ti_sel   = dtemp_s3[18] ? tilo_s3 : {5'd0, tihi_s3};
		tsum     = $signed(21'd2000) + 21'(dtemp_s3) - $signed({3'b000, ti_sel});
		if (tsum < TEMP_MIN)
			t_c = 15'(TEMP_MIN);
		else if (tsum > TEMP_MAX)
			t_c = 15'(TEMP_MAX);
		else
			t_c = tsum[14:0];

		// s5: second-order corrections
		aux3  = {2'b00, aux_s4} + {1'b0, aux_s4, 1'b0};
		aux5  = {3'b000, aux_s4} + {1'b0, aux_s4, 2'b00};
		offi  = neg_s4 ? aux3[38:1] : {5'd0, aux_s4[36:4]};
		sensi = neg_s4 ? aux5[39:3] : '0;

		// s8: D1*SENS / 2^21
		prod_b = prod_s7 + $signed({42'd0, {21{prod_s7[62]}}});

		// s10: / 2^13 and saturate
		diff_b = diff_s9 + $signed({30'd0, {13{diff_s9[42]}}});
		praw   = $signed(diff_b[42:13]);
		if (praw < 0)
			p_c = '0;
		else if (praw > PRES_MAX)
			p_c = 19'(PRES_MAX);
		else
			p_c = praw[18:0];

		// s11/s12: depth
		dsub = $signed({1'b0, p_s10}) - $signed({1'b0, surf_q});
		dsh  = $signed(dprod_s11[37:16]);
		if (dsh < -DEPTH_LIMIT)
			depth_c = 20'(-DEPTH_LIMIT);
		else if (dsh > DEPTH_LIMIT)
			depth_c = 20'(DEPTH_LIMIT);
		else
			depth_c = dsh[19:0];
	end

	always_ff @(posedge clk) begin
		// s1
		d1_s1 <= sample.raw_pressure;
		dt_s1 <= dt_c;
		// s2
		d1_s2 <= d1_s1;
		mt_s2 <= dt_s1 * $signed({1'b0, c6_q});
		mo_s2 <= dt_s1 * $signed({1'b0, c4_q});
		ms_s2 <= dt_s1 * $signed({1'b0, c3_q});
		dd_s2 <= dd_full[48:0];
		// s3
		d1_s3    <= d1_s2;
		dtemp_s3 <= $signed(mt_b[41:23]);
		off_s3   <= $signed({4'd0, c2_q, 16'd0}) + 36'(mo_tr);
		sens_s3  <= $signed({4'd0, c1_q, 15'd0}) + 35'(ms_tr);
		tilo_s3  <= dd3[50:33];
		tihi_s3  <= dd_s2[48:36];
		// s4
		d1_s4   <= d1_s3;
		off_s4  <= off_s3;
		sens_s4 <= sens_s3;
		aux_s4  <= aux_full[36:0];
		neg_s4  <= dtemp_s3[18];
		t_s4    <= t_c;
		// s5
		d1_s5   <= d1_s4;
		off_s5  <= 40'(off_s4) - $signed({2'b00, offi});
		sens_s5 <= 38'(sens_s4) - $signed({1'b0, sensi});
		t_s5    <= t_s4;
		// s6: split product
		off_s6  <= off_s5;
		pplo_s6 <= d1_s5 * sens_s5[18:0];
		pphi_s6 <= $signed({1'b0, d1_s5}) * $signed(sens_s5[37:19]);
		t_s6    <= t_s5;
		// s7
		off_s7  <= off_s6;
		prod_s7 <= $signed({pphi_s6, 19'd0}) + $signed({20'd0, pplo_s6});
		t_s7    <= t_s6;
		// s8
		off_s8 <= off_s7;
		q_s8   <= $signed(prod_b[62:21]);
		t_s8   <= t_s7;
		// s9
		diff_s9 <= 43'(q_s8) - 43'(off_s8);
		t_s9    <= t_s8;
		// s10
		p_s10 <= p_c;
		t_s10 <= t_s9;
		// s11
		p_s11     <= p_s10;
		dprod_s11 <= dsub * DEPTH_SCALE;
		t_s11     <= t_s10;
		// s12
		result_s12.temperature_centi   <= t_s11;
		result_s12.pressure_tenth_mbar <= p_s11;
		result_s12.depth_value         <= depth_c;
	end

	`PSC_ASSERT_IMPLY(a_done_follows_item, clk, arst_n, done,
		$past(accept, PIPE_DEPTH), "result without an item taken PIPE_DEPTH cycles before")
	`PSC_ASSERT_IMPLY(a_temp_range, clk, arst_n, done,
		(result.temperature_centi >= TEMP_MIN) && (result.temperature_centi <= TEMP_MAX),
		"temperature outside saturation range")
	`PSC_ASSERT_IMPLY(a_pres_range, clk, arst_n, done,
		result.pressure_tenth_mbar <= PRES_MAX, "pressure above saturation limit")
	`PSC_ASSERT_IMPLY(a_depth_zero, clk, arst_n,
		done && (result.pressure_tenth_mbar == surf_q),
		result.depth_value == 20'sd0, "nonzero depth at surface pressure")
	`PSC_ASSERT_NEXT(a_item_reaches_s1, clk, arst_n, accept,
		vld_q[0], "accepted item lost at stage 1")

endmodule
